@@ src/sbr_pkg.sv @@
// ---------------------------------------------------------------------------
// sbr_pkg: shared types and constants for the stack with bottom removal
// Operation codes, default sizes and the controller-to-datapath command.
// ---------------------------------------------------------------------------
package sbr_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int TYPE_BITS_DEF  = 4;
  localparam int AMOUNT_BITS    = 8;
  localparam int OP_BITS        = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_TAKE = 2'd2,
    OP_PEEK = 2'd3
  } op_t;

  // exec: perform the accepted request this cycle; load: fill the result register
  typedef struct packed {
    logic exec;
    logic load;
  } dp_cmd_t;

endpackage

@@ src/sbr_ram.sv @@
// ---------------------------------------------------------------------------
// sbr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/sbr_dp.sv @@
// ---------------------------------------------------------------------------
// sbr_dp: stack datapath
// Ring pointers, entry count, entry RAM and the result register.
// ---------------------------------------------------------------------------
module sbr_dp #(
  parameter int DEPTH      = sbr_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sbr_pkg::VALUE_BITS_DEF,
  parameter int TYPE_BITS  = sbr_pkg::TYPE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sbr_pkg::dp_cmd_t                 cmd,
  input  logic [sbr_pkg::OP_BITS-1:0]      in_operation,
  input  logic [VALUE_BITS-1:0]            in_value,
  input  logic [TYPE_BITS-1:0]             in_type_code,
  input  logic [sbr_pkg::AMOUNT_BITS-1:0]  in_amount,
  output logic [VALUE_BITS-1:0]            out_read_value,
  output logic [TYPE_BITS-1:0]             out_read_type,
  output logic                             out_found,
  output logic                             out_overflow,
  output logic [$clog2(DEPTH+1)-1:0]       out_entry_count
);

  import sbr_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > AMOUNT_BITS) ? CW : AMOUNT_BITS;
  localparam int RW   = VALUE_BITS + TYPE_BITS;
  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [IW-1:0]         bottom_r, bottom_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  found_r, found_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [IW-1:0]         offset;
  logic [IW:0]           slot_sum;
  logic [IW-1:0]         slot;
  logic [IW:0]           bump_sum;
  logic [CMPW-1:0]       amt_x;
  logic [CMPW-1:0]       count_x;
  logic                  we, re;
  logic [RW-1:0]         rdata;
  logic [VALUE_BITS-1:0] value_r;
  logic [TYPE_BITS-1:0]  type_r;
  logic                  out_found_r, out_ovf_r;
  logic [CW-1:0]         out_count_r;

  assign amt_x   = CMPW'(in_amount);
  assign count_x = CMPW'(count_r);

  // slot = (bottom + offset) mod DEPTH, both terms below DEPTH
  assign slot_sum = {1'b0, bottom_r} + {1'b0, offset};
  assign slot     = (slot_sum >= DEPTH_W) ? IW'(slot_sum - DEPTH_W) : slot_sum[IW-1:0];
  assign bump_sum = {1'b0, bottom_r} + (IW + 1)'(1);

  always_comb begin
    bottom_nxt = bottom_r;
    count_nxt  = count_r;
    found_nxt  = 1'b0;
    ovf_nxt    = 1'b0;
    offset     = '0;
    we         = 1'b0;
    re         = 1'b0;
    if (cmd.exec) begin
      case (op_t'(in_operation))
        OP_PUSH: begin
          if (count_r == DEPTH_C) begin
            ovf_nxt = 1'b1;
          end else begin
            offset    = count_r[IW-1:0];
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_POP: begin
          if (amt_x >= count_x) begin
            count_nxt = '0;
          end else begin
            count_nxt = CW'(count_x - amt_x);
          end
        end
        OP_TAKE: begin
          if (count_r != '0) begin
            re         = 1'b1;
            found_nxt  = 1'b1;
            bottom_nxt = (bump_sum == DEPTH_W) ? '0 : bump_sum[IW-1:0];
            count_nxt  = count_r - CW'(1);
          end
        end
        OP_PEEK: begin
          if (amt_x < count_x) begin
            offset    = IW'(count_x - CMPW'(1) - amt_x);
            re        = 1'b1;
            found_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  sbr_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata ({in_value, in_type_code}),
    .re    (re),
    .raddr (slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_r <= '0;
      count_r  <= '0;
    end else begin
      bottom_r <= bottom_nxt;
      count_r  <= count_nxt;
    end
  end

  // hold per-request flags until the result register is filled
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
    end
    if (cmd.load) begin
      value_r     <= found_r ? rdata[RW-1:TYPE_BITS] : '0;
      type_r      <= found_r ? rdata[TYPE_BITS-1:0] : '0;
      out_found_r <= found_r;
      out_ovf_r   <= ovf_r;
      out_count_r <= count_r;
    end
  end

  assign out_read_value  = value_r;
  assign out_read_type   = type_r;
  assign out_found       = out_found_r;
  assign out_overflow    = out_ovf_r;
  assign out_entry_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  a_bottom_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, bottom_r} < DEPTH_W)
    else $error("bottom pointer out of range");

  a_empty_no_find: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (count_r == '0) |=> !found_r && !(found_r && ovf_r))
    else $error("entry found in empty stack");

endmodule

@@ src/sbr_ctrl.sv @@
// ---------------------------------------------------------------------------
// sbr_ctrl: stack controller
// Sequences accept, execute and result load; owns the output valid.
// ---------------------------------------------------------------------------
module sbr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sbr_pkg::dp_cmd_t cmd
);

  import sbr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // refuse requests while reset is held
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign cmd.exec  = in_valid && in_ready;
  assign cmd.load  = (state_r == S_LOAD) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.exec) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_exec_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec)
    else $error("back-to-back execute");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load)
    else $error("result loaded twice");

endmodule

@@ src/stack_with_bottom_removal.sv @@
// ---------------------------------------------------------------------------
// stack_with_bottom_removal: bounded stack in a ring buffer
// Push, multi-pop, take-bottom and peek on a stack of value/type entries.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: operation, value,
//   type code and amount. Output channel (out_valid/out_ready) returns exactly
//   one result per request: read value and type, found, overflow and the
//   entry count after the request.
//   Result: an accepted request moves the controller to S_LOAD, which loads the
//   result register once the output is free; out_valid rises after that load.
//   Pacing: a new request is taken only once the previous result is loaded; the
//   accept cycle performs at most one RAM access and the pointer update, and
//   S_LOAD loads the result register from the registered RAM read port.
//   Stall: while the receiver holds out_ready low, the result register holds
//   its item; one more request is accepted and executed, then the block waits
//   to load that result until the pending one is taken.
//   Reset: entry count and bottom pointer clear to zero and in_ready stays low
//   while reset is held; RAM contents are not cleared, so no clearing pass is
//   needed and requests are taken as soon as reset is released.
// ---------------------------------------------------------------------------
module stack_with_bottom_removal #(
  parameter int DEPTH      = sbr_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sbr_pkg::VALUE_BITS_DEF,
  parameter int TYPE_BITS  = sbr_pkg::TYPE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sbr_pkg::OP_BITS-1:0]     in_operation,
  input  logic [VALUE_BITS-1:0]           in_value,
  input  logic [TYPE_BITS-1:0]            in_type_code,
  input  logic [sbr_pkg::AMOUNT_BITS-1:0] in_amount,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [VALUE_BITS-1:0]           out_read_value,
  output logic [TYPE_BITS-1:0]            out_read_type,
  output logic                            out_found,
  output logic                            out_overflow,
  output logic [$clog2(DEPTH+1)-1:0]      out_entry_count
);

  import sbr_pkg::*;

  // execute/load commands from the controller to the datapath
  dp_cmd_t cmd;

  sbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: pointers, count, entry RAM and result register
  sbr_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .TYPE_BITS  (TYPE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .in_type_code    (in_type_code),
    .in_amount       (in_amount),
    .out_read_value  (out_read_value),
    .out_read_type   (out_read_type),
    .out_found       (out_found),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count)
  );

endmodule
